// ===== sv/keyed_crc32_seal_and_verify_assert.svh =====
// Assertion macros for the keyed CRC-32 seal and verify block
`ifndef KEYED_CRC32_SEAL_AND_VERIFY_ASSERT_SVH
`define KEYED_CRC32_SEAL_AND_VERIFY_ASSERT_SVH

// same-cycle implication, sampled on clk, off during rst
`define KCSV_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("keyed crc32 assertion failed");

// next-cycle implication, sampled on clk, off during rst
`define KCSV_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("keyed crc32 assertion failed");

`endif

// ===== sv/kcsv_pkg.sv =====
// Types, constants and byte functions shared by the keyed CRC-32 block
`default_nettype none

package kcsv_pkg;

  localparam int PAYLOAD_LENGTH_W = 10;
  localparam int CFG_INDEX_W      = 2;
  localparam int CFG_DATA_W       = 10;
  localparam logic [31:0] CRC_POLY = 32'hEDB88320;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_MODE           = 2'd0,
    CFG_PAYLOAD_LENGTH = 2'd1,
    CFG_PAD_KEY        = 2'd2
  } cfg_index_t;

  typedef enum logic {
    MODE_SEAL   = 1'b0,
    MODE_VERIFY = 1'b1
  } mode_t;

  typedef enum logic [1:0] {
    PAD_NONE   = 2'b00,
    PAD_FLIP   = 2'b01,
    PAD_INVERT = 2'b10,
    PAD_ROTATE = 2'b11
  } pad_op_t;

  typedef struct packed {
    mode_t                       mode;
    logic [PAYLOAD_LENGTH_W-1:0] payload_length;
    logic [7:0]                  pad_key;
  } cfg_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic [7:0] key_byte;
  } item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       end_of_message;
    logic       crc_ok;
  } result_t;

  function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'h0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic [7:0] pad_step(input logic [7:0] b, input pad_op_t op,
                                          input logic [1:0] i, input logic forward);
    logic [7:0] mask;
    logic [7:0] r;
    mask = 8'h80 >> i;
    unique case (op)
      PAD_NONE:   r = b;
      PAD_FLIP:   r = b ^ mask;
      PAD_INVERT: r = b ^ ~mask;
      PAD_ROTATE: r = forward ? {b[6:0], b[7]} : {b[0], b[7:1]};
      default:    r = b;
    endcase
    return r;
  endfunction

  function automatic pad_op_t pad_op_of(input logic [7:0] key, input logic [1:0] i);
    logic [7:0] sh;
    sh = key >> (3'd6 - {i, 1'b0});
    return pad_op_t'(sh[1:0]);
  endfunction

  function automatic logic [7:0] pad_byte(input logic [7:0] b, input logic [7:0] key);
    logic [7:0] r;
    r = b;
    for (int i = 0; i < 4; i++) begin
      r = pad_step(r, pad_op_of(key, 2'(i)), 2'(i), 1'b1);
    end
    return r;
  endfunction

  function automatic logic [7:0] depad_byte(input logic [7:0] b, input logic [7:0] key);
    logic [7:0] r;
    r = b;
    for (int i = 3; i >= 0; i--) begin
      r = pad_step(r, pad_op_of(key, 2'(i)), 2'(i), 1'b0);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== sv/kcsv_cfg_regs.sv =====
// Configuration registers: mode, payload length and pad key
`default_nettype none

module kcsv_cfg_regs import kcsv_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  output cfg_t                        cfg
);

  cfg_t cfg_next;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_next = cfg;
    if (cfg_valid) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_MODE:           cfg_next.mode = mode_t'(cfg_data[0]);
        CFG_PAYLOAD_LENGTH: cfg_next.payload_length = cfg_data[PAYLOAD_LENGTH_W-1:0];
        CFG_PAD_KEY:        cfg_next.pad_key = cfg_data[7:0];
        default:            cfg_next = cfg;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode           <= MODE_SEAL;
      cfg.payload_length <= PAYLOAD_LENGTH_W'(1);
      cfg.pad_key        <= 8'h00;
    end else begin
      cfg <= cfg_next;
    end
  end

endmodule

`default_nettype wire

// ===== sv/kcsv_in_stage.sv =====
// Input register stage with stall toward the item source
`default_nettype none

module kcsv_in_stage import kcsv_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       item_valid,
  output logic            item_stall,
  input  wire logic [7:0] data_byte,
  input  wire logic [7:0] key_byte,
  input  wire logic       advance,
  output logic            held_valid,
  output item_t           held_item
);

  logic load;

  assign item_stall = held_valid && !advance;
  assign load       = item_valid && !item_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (load) begin
      held_valid <= 1'b1;
    end else if (advance) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held_item.data_byte <= data_byte;
      held_item.key_byte  <= key_byte;
    end
  end

endmodule

`default_nettype wire

// ===== sv/kcsv_core.sv =====
// Byte XOR, running CRC-32, tail emission and tail check
`default_nettype none

`include "keyed_crc32_seal_and_verify_assert.svh"

module kcsv_core import kcsv_pkg::*; #(
  parameter int MAX_PAYLOAD_BYTES = 512
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire cfg_t  cfg,
  input  wire logic  fire,
  input  wire item_t item,
  output result_t    result
);

  localparam int POS_W = $clog2(MAX_PAYLOAD_BYTES + 4);
  localparam int CMP_W = (POS_W > PAYLOAD_LENGTH_W) ? POS_W : PAYLOAD_LENGTH_W;
  localparam logic [CMP_W-1:0] MAX_LEN = CMP_W'(MAX_PAYLOAD_BYTES);
  localparam logic [CMP_W-1:0] LAST_TAIL = CMP_W'(3);

  logic [31:0]      crc_running;
  logic [31:0]      crc_running_next;
  logic [POS_W-1:0] position_count;
  logic [POS_W-1:0] position_count_next;
  logic [23:0]      tail_store;
  logic [23:0]      tail_store_next;

  logic [CMP_W-1:0] len;
  logic [CMP_W-1:0] pl_ext;
  logic [CMP_W-1:0] pos_ext;
  logic [CMP_W-1:0] tail_off;
  logic [1:0]       tail_idx;
  logic             in_payload;
  logic [31:0]      crc_final;
  logic [7:0]       plain_xor;
  logic [7:0]       crc_sel;
  logic [31:0]      got;

  always_comb begin
    pl_ext     = CMP_W'(cfg.payload_length);
    len        = (pl_ext > MAX_LEN) ? MAX_LEN : pl_ext;
    pos_ext    = CMP_W'(position_count);
    in_payload = pos_ext < len;
    tail_off   = pos_ext - len;
    tail_idx   = (tail_off > LAST_TAIL) ? 2'd3 : tail_off[1:0];
    crc_final  = ~crc_running;
    plain_xor  = item.data_byte ^ item.key_byte;

    unique case (tail_idx)
      2'd0:    crc_sel = pad_byte(crc_final[31:24], cfg.pad_key);
      2'd1:    crc_sel = crc_final[23:16];
      2'd2:    crc_sel = crc_final[15:8];
      default: crc_sel = crc_final[7:0];
    endcase

    got = {depad_byte(tail_store[23:16], cfg.pad_key), tail_store[15:0], plain_xor};

    result.end_of_message = !in_payload && (tail_idx == 2'd3);
    result.crc_ok = result.end_of_message && (cfg.mode == MODE_VERIFY) && (got == crc_final);
    if (in_payload || cfg.mode == MODE_VERIFY) begin
      result.out_byte = plain_xor;
    end else begin
      result.out_byte = crc_sel ^ item.key_byte;
    end
  end

  always_comb begin
    crc_running_next    = crc_running;
    position_count_next = position_count;
    tail_store_next     = tail_store;
    if (in_payload) begin
      crc_running_next = crc32_byte(crc_running,
                                    (cfg.mode == MODE_VERIFY) ? plain_xor : item.data_byte);
      position_count_next = position_count + POS_W'(1);
    end else if (tail_idx == 2'd3) begin
      crc_running_next    = '1;
      position_count_next = '0;
    end else begin
      position_count_next = position_count + POS_W'(1);
      if (cfg.mode == MODE_VERIFY) begin
        unique case (tail_idx)
          2'd0:    tail_store_next[23:16] = plain_xor;
          2'd1:    tail_store_next[15:8]  = plain_xor;
          default: tail_store_next[7:0]   = plain_xor;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_running    <= '1;
      position_count <= '0;
    end else if (fire) begin
      crc_running    <= crc_running_next;
      position_count <= position_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      tail_store <= tail_store_next;
    end
  end

  `KCSV_ASSERT_NEXT(a_restart_after_end, fire && result.end_of_message, crc_running == '1 && position_count == '0)
  `KCSV_ASSERT_IMPL(a_ok_only_on_verify_end, result.crc_ok, result.end_of_message && cfg.mode == MODE_VERIFY)
  `KCSV_ASSERT_IMPL(a_position_bound, 1'b1, position_count <= POS_W'(MAX_PAYLOAD_BYTES + 3))

endmodule

`default_nettype wire

// ===== sv/kcsv_out_stage.sv =====
// Result register stage with stall from the result sink
`default_nettype none

module kcsv_out_stage import kcsv_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    held_valid,
  input  wire result_t result,
  output logic         advance,
  output logic         result_valid,
  input  wire logic    result_stall,
  output logic [7:0]   out_byte,
  output logic         end_of_message,
  output logic         crc_ok
);

  result_t result_q;

  assign advance        = !result_valid || !result_stall;
  assign out_byte       = result_q.out_byte;
  assign end_of_message = result_q.end_of_message;
  assign crc_ok         = result_q.crc_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= held_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && held_valid) begin
      result_q <= result;
    end
  end

endmodule

`default_nettype wire

// ===== sv/keyed_crc32_seal_and_verify.sv =====
// Top level of the keyed CRC-32 seal and verify block
`default_nettype none

// Takes one item per clock while result_stall is low and returns one result per item:
// an input register holds the accepted item, a single combinational pass does the key
// XOR, the byte-wide CRC-32 update and the tail pad, depad and compare, and a result
// register presents the outcome. The byte CRC update, eight folded polynomial steps on
// the 32-bit running value, sets the clock period. item_stall follows result_stall in
// the same cycle. The CRC and position restart by themselves after each final tail item;
// no clearing pass follows reset.
module keyed_crc32_seal_and_verify import kcsv_pkg::*; #(
  parameter int MAX_PAYLOAD_BYTES = 512
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                   item_valid,
  output logic                        item_stall,
  input  wire logic [7:0]             data_byte,
  input  wire logic [7:0]             key_byte,
  output logic                        result_valid,
  input  wire logic                   result_stall,
  output logic [7:0]                  out_byte,
  output logic                        end_of_message,
  output logic                        crc_ok
);

  cfg_t    cfg;
  item_t   held_item;
  result_t result;
  logic    held_valid;
  logic    advance;
  logic    fire;

  assign fire = held_valid && advance;

  kcsv_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  kcsv_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .data_byte  (data_byte),
    .key_byte   (key_byte),
    .advance    (advance),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  kcsv_core #(
    .MAX_PAYLOAD_BYTES (MAX_PAYLOAD_BYTES)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .fire   (fire),
    .item   (held_item),
    .result (result)
  );

  kcsv_out_stage u_out (
    .clk            (clk),
    .rst            (rst),
    .held_valid     (held_valid),
    .result         (result),
    .advance        (advance),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .out_byte       (out_byte),
    .end_of_message (end_of_message),
    .crc_ok         (crc_ok)
  );

endmodule

`default_nettype wire

// ===== tb/tb_keyed_crc32_seal_and_verify.sv =====
// Self-checking testbench for the keyed CRC-32 seal and verify block
module tb_keyed_crc32_seal_and_verify import kcsv_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_PAYLOAD = 512;
  localparam int LATENCY = 2;
  localparam int QUIET_LIMIT = 3000;
  localparam int ITEMS_PER_PHASE = 20;
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE = 2'd3;

  class seal_crc_tracker;
    mode_t mode;
    logic [PAYLOAD_LENGTH_W-1:0] length_reg;
    logic [7:0] pad_key;
    logic [31:0] crc_state;
    int position;
    logic [23:0] tail_bytes;
    result_t awaited_results[$];
    int errors;

    function new();
      mode = MODE_SEAL;
      length_reg = 1;
      pad_key = 8'h00;
      crc_state = '1;
      position = 0;
      tail_bytes = '0;
      errors = 0;
    endfunction

    function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_MODE:           mode = mode_t'(val[0]);
        CFG_PAYLOAD_LENGTH: length_reg = val[PAYLOAD_LENGTH_W-1:0];
        CFG_PAD_KEY:        pad_key = val[7:0];
        default: ;
      endcase
    endfunction

    function logic [31:0] crc_feed(logic [31:0] c, logic [7:0] b);
      c ^= {24'h0, b};
      repeat (8) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      return c;
    endfunction

    function logic [7:0] pad_pass(logic [7:0] b, bit fwd);
      logic [7:0] r;
      logic [7:0] bitm;
      pad_op_t op;
      int j;
      r = b;
      for (int n = 0; n < 4; n++) begin
        j = fwd ? n : 3 - n;
        op = pad_op_t'(pad_key[7 - 2*j -: 2]);
        bitm = 8'h80 >> j;
        case (op)
          PAD_FLIP:   r = r ^ bitm;
          PAD_INVERT: r = r ^ ~bitm;
          PAD_ROTATE: r = fwd ? {r[6:0], r[7]} : {r[0], r[7:1]};
          default: ;
        endcase
      end
      return r;
    endfunction

    // -1 while in the payload, else the tail slot 0..3
    function int tail_slot();
      int eff;
      eff = (length_reg > MAX_PAYLOAD) ? MAX_PAYLOAD : int'(length_reg);
      if (position < eff) return -1;
      return (position - eff > 3) ? 3 : position - eff;
    endfunction

    function void absorb_item(logic [7:0] d, logic [7:0] k);
      result_t r;
      int t;
      logic [31:0] c;
      logic [7:0] b;
      r = '0;
      t = tail_slot();
      c = ~crc_state;
      if (t < 0) begin
        r.out_byte = d ^ k;
        crc_state = crc_feed(crc_state, (mode == MODE_VERIFY) ? r.out_byte : d);
        position++;
      end else begin
        if (mode == MODE_SEAL) begin
          b = c[31 - 8*t -: 8];
          if (t == 0) b = pad_pass(b, 1'b1);
          r.out_byte = b ^ k;
        end else begin
          r.out_byte = d ^ k;
          if (t < 3) tail_bytes[23 - 8*t -: 8] = r.out_byte;
          else r.crc_ok = ({pad_pass(tail_bytes[23:16], 1'b0), tail_bytes[15:0], r.out_byte} == c);
        end
        if (t == 3) begin
          r.end_of_message = 1'b1;
          position = 0;
          crc_state = '1;
        end else begin
          position++;
        end
      end
      awaited_results.push_back(r);
    endfunction

    task report(string msg);
      $display("[%0t] MISMATCH: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(logic [7:0] ob, logic eom, logic ok);
      result_t e;
      if (awaited_results.size() == 0) begin
        report($sformatf("result with nothing awaited, out_byte=%02h", ob));
        return;
      end
      e = awaited_results.pop_front();
      if (ob !== e.out_byte)
        report($sformatf("out_byte %02h, want %02h", ob, e.out_byte));
      if (eom !== e.end_of_message)
        report($sformatf("end_of_message %b, want %b", eom, e.end_of_message));
      if (ok !== e.crc_ok)
        report($sformatf("crc_ok %b, want %b", ok, e.crc_ok));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic item_valid = 1'b0;
  logic item_stall;
  logic [7:0] data_byte = 8'h00;
  logic [7:0] key_byte = 8'h00;
  logic result_valid;
  logic result_stall = 1'b0;
  logic [7:0] out_byte;
  logic end_of_message;
  logic crc_ok;

  seal_crc_tracker chk;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int items_sent = 0;
  int quiet_cycles = 0;

  keyed_crc32_seal_and_verify #(.MAX_PAYLOAD_BYTES(MAX_PAYLOAD)) DUT (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .data_byte(data_byte),
    .key_byte(key_byte),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .out_byte(out_byte),
    .end_of_message(end_of_message),
    .crc_ok(crc_ok)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (result_valid && !result_stall) chk.check_result(out_byte, end_of_message, crc_ok);
      result_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall)
        || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    chk.write_reg(idx, val);
  endtask

  task automatic cfg_release();
    cfg_valid <= 1'b0;
  endtask

  task automatic send_item(input logic [7:0] d, input logic [7:0] k);
    while ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    data_byte <= d;
    key_byte <= k;
    do @(posedge clk); while (item_stall);
    chk.absorb_item(d, k);
    items_sent++;
  endtask

  // build a matching tail in verify mode when good, flip one bit of tail slot flip_t
  task automatic send_next(input bit good, input int flip_t);
    logic [7:0] d;
    logic [7:0] k;
    logic [7:0] cb;
    logic [31:0] c;
    int t;
    d = 8'($urandom);
    k = 8'($urandom);
    t = chk.tail_slot();
    if (t >= 0 && chk.mode == MODE_VERIFY && good) begin
      c = ~chk.crc_state;
      cb = c[31 - 8*t -: 8];
      if (t == 0) cb = chk.pad_pass(cb, 1'b1);
      d = cb ^ k;
      if (t == flip_t) d = d ^ (8'h01 << $urandom_range(7));
    end
    send_item(d, k);
  endtask

  task automatic finish_message(input bit good);
    do send_next(good, -1); while (chk.position != 0);
  endtask

  task automatic drain();
    item_valid <= 1'b0;
    while (chk.awaited_results.size() != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  task automatic new_settings();
    logic [CFG_DATA_W-1:0] len;
    case ($urandom_range(9))
      0:       len = CFG_DATA_W'($urandom_range(3));
      1, 2:    len = CFG_DATA_W'($urandom_range(64, 17));
      default: len = CFG_DATA_W'($urandom_range(16, 1));
    endcase
    drain();
    if ($urandom_range(1)) cfg_write(CFG_MODE, {9'($urandom), 1'($urandom)});
    cfg_write(CFG_PAYLOAD_LENGTH, len);
    if ($urandom_range(1)) cfg_write(CFG_PAD_KEY, {2'($urandom), 8'($urandom)});
    if ($urandom_range(19) == 0) cfg_write(CFG_SPARE, CFG_DATA_W'($urandom));
    cfg_release();
  endtask

  task automatic run_message();
    bit good;
    int flip_t;
    int break_at;
    int n;
    good = ($urandom_range(99) < 85);
    flip_t = (good && $urandom_range(99) < 20) ? int'($urandom_range(3)) : -1;
    break_at = ($urandom_range(9) == 0) ? int'($urandom_range(20)) : -1;
    n = 0;
    do begin
      if (n == break_at) begin
        drain();
        cfg_write(CFG_PAYLOAD_LENGTH, CFG_DATA_W'($urandom_range(24)));
        if ($urandom_range(2) == 0) cfg_write(CFG_MODE, {9'($urandom), ~chk.mode});
        cfg_release();
      end
      send_next(good, flip_t);
      n++;
    end while (chk.position != 0);
  endtask

  initial begin
    int phase_end;
    chk = new();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    cfg_write(CFG_MODE, {9'h000, MODE_SEAL});
    cfg_write(CFG_PAYLOAD_LENGTH, 10'd0);
    cfg_write(CFG_PAD_KEY, 10'h0FF);
    cfg_write(CFG_SPARE, 10'h3FF);
    cfg_release();
    finish_message(1'b1);

    drain();
    cfg_write(CFG_PAYLOAD_LENGTH, 10'd2);
    cfg_write(CFG_PAD_KEY, 10'h31B);
    cfg_release();
    send_item(8'h00, 8'hFF);
    send_item(8'hFF, 8'h00);
    finish_message(1'b1);

    drain();
    cfg_write(CFG_MODE, {9'h1FF, MODE_VERIFY});
    cfg_write(CFG_PAD_KEY, 10'h0E4);
    cfg_release();
    send_item(8'hFF, 8'hFF);
    send_item(8'h00, 8'h00);
    finish_message(1'b1);

    drain();
    cfg_write(CFG_MODE, {9'h0AA, MODE_SEAL});
    cfg_write(CFG_PAYLOAD_LENGTH, 10'd5);
    cfg_release();
    repeat (5) send_next(1'b1, -1);
    // shrink length mid-message: position lands past the last tail slot
    drain();
    cfg_write(CFG_PAYLOAD_LENGTH, 10'd1);
    cfg_release();
    finish_message(1'b1);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0; stall_pct = 0; end
        1: begin send_idle_pct = 84; stall_pct = 0; end
        2: begin send_idle_pct = 0; stall_pct = 84; end
        default: begin send_idle_pct = 10; stall_pct = 10; end
      endcase
      if (ph == 0) begin
        // oversized length, clamped to the maximum payload
        drain();
        cfg_write(CFG_MODE, {9'h155, MODE_VERIFY});
        cfg_write(CFG_PAYLOAD_LENGTH, 10'h3FF);
        cfg_release();
        finish_message(1'b1);
      end
      phase_end = items_sent + ITEMS_PER_PHASE;
      while (items_sent < phase_end) begin
        new_settings();
        run_message();
      end
    end

    drain();
    if (chk.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
